[rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Slot, count and tick widths, operation and status codes, slot table bus.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    localparam int MAX_THREADS = 32;
    localparam int TICK_BITS   = 32;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int SLICE_W     = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int LINK_AW     = SLOT_W + 1;

    localparam logic [SLICE_W-1:0] SLICE_RESET     = SLICE_W'(5);
    localparam logic [SLOT_W-1:0]  IDLE_RESET      = SLOT_W'(0);
    localparam logic [SLOT_W-1:0]  BOOTSTRAP_RESET = SLOT_W'(1);

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_SLEEP   = 3'd1,
        OP_TICK    = 3'd2,
        OP_YIELD   = 3'd3,
        OP_BLOCK   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_BLOCKED = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2
    } stat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE     = 2'd0,
        CFG_IDLE      = 2'd1,
        CFG_BOOTSTRAP = 2'd2
    } cfg_idx_t;

    // which list a link RAM entry belongs to (upper address bit)
    localparam logic LIST_READY = 1'b0;
    localparam logic LIST_SLEEP = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_UNL,
        S_UNL_W,
        S_INS_START,
        S_INS,
        S_INS_W,
        S_INS_END,
        S_INS_LINK,
        S_TK,
        S_TK_W,
        S_Y_ENQ,
        S_Y_DEQ,
        S_Y_DEQ_W,
        S_Y_FIN
    } fsm_t;

    typedef struct packed {
        logic  stat_we;
        slot_t stat_addr;
        stat_t stat_val;
        logic  mark_we;
        slot_t mark_addr;
        logic  mark_val;
    } slot_wr_t;

endpackage

`default_nettype wire

[rtl/rrts_ram.sv]
// ----------------------------------------------------------------------------
// rrts_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/rrts_slot_table.sv]
// ----------------------------------------------------------------------------
// rrts_slot_table: per-slot status and in-queue mark
// One write per field per cycle, one shared read address.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_slot_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rrts_pkg::slot_wr_t wr,
    input  wire rrts_pkg::slot_t   rd_addr,
    output rrts_pkg::stat_t        rd_stat,
    output logic                   rd_mark
);

    rrts_pkg::stat_t stat_reg [rrts_pkg::MAX_THREADS];
    logic [rrts_pkg::MAX_THREADS-1:0] mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrts_pkg::MAX_THREADS; i++)
            begin
                stat_reg[i] <= (rrts_pkg::SLOT_W'(i) == rrts_pkg::BOOTSTRAP_RESET) ?
                               rrts_pkg::ST_RUNNING : rrts_pkg::ST_BLOCKED;
            end
            mark_reg <= '0;
        end
        else
        begin
            if (wr.stat_we)
            begin
                stat_reg[wr.stat_addr] <= wr.stat_val;
            end
            if (wr.mark_we)
            begin
                mark_reg[wr.mark_addr] <= wr.mark_val;
            end
        end
    end

    assign rd_stat = stat_reg[rd_addr];
    assign rd_mark = mark_reg[rd_addr];

endmodule

`default_nettype wire

[rtl/round_robin_thread_scheduler_top.sv]
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top: round-robin thread scheduler
// FIFO ready queue and tick-sorted sleep list kept in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation, thread_id, wake_tick and now_tick and
//   raise start; the word is taken at the clock edge where start is high and
//   busy is low. busy stays high until the result word is shown.
//   Result channel: done is high for exactly one cycle with current_thread,
//   switched, need_reschedule, woken_count and ready_count. The receiver
//   cannot stall; the word is gone after that cycle. busy is already low in
//   the done cycle, so the next command may be taken at its end.
//   Configuration: cfg_write/cfg_index/cfg_data write a register; the user
//   must write only while no command is in flight; the block does not enforce it.
// Sequencing: each list step is a read of the link and wake-tick RAMs,
//   whose read data is registered, followed by a decision state.
//   Sleep walks the sleep list once to unlink the thread and again to
//   find the insert point; timer tick pops due sleepers one by one and
//   ends on a read of a sleeper that is not yet due, which stays in the list.
// Reset: ready queue and sleep list empty, the bootstrap slot (1) is running,
//   time slice 5, idle slot 0. RAM contents need no clearing; entries are only
//   read after being linked in.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // command channel
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [2:0]                           operation,
    input  wire logic [rrts_pkg::SLOT_W-1:0]          thread_id,
    input  wire logic [rrts_pkg::TICK_BITS-1:0]       wake_tick,
    input  wire logic [rrts_pkg::TICK_BITS-1:0]       now_tick,
    // result channel
    output logic                                      done,
    output logic [rrts_pkg::SLOT_W-1:0]               current_thread,
    output logic                                      switched,
    output logic                                      need_reschedule,
    output logic [rrts_pkg::CNT_W-1:0]                woken_count,
    output logic [rrts_pkg::CNT_W-1:0]                ready_count,
    // configuration
    input  wire logic                                 cfg_write,
    input  wire logic [rrts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rrts_pkg::CFG_W-1:0]           cfg_data
);

    // ---------------- registers ----------------
    rrts_pkg::fsm_t  state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    rrts_pkg::slot_t tid_reg, tid_next;
    rrts_pkg::tick_t wake_reg, wake_next;
    rrts_pkg::tick_t now_reg, now_next;

    rrts_pkg::slot_t r_head_reg, r_head_next;
    rrts_pkg::slot_t r_tail_reg, r_tail_next;
    rrts_pkg::cnt_t  r_total_reg, r_total_next;
    rrts_pkg::slot_t s_head_reg, s_head_next;
    rrts_pkg::cnt_t  s_total_reg, s_total_next;
    rrts_pkg::slot_t running_reg, running_next;
    logic [rrts_pkg::SLICE_W-1:0] slice_reg, slice_next;
    logic            resched_reg, resched_next;

    // list walk
    rrts_pkg::slot_t cur_reg, cur_next;
    rrts_pkg::slot_t prev_reg, prev_next;
    rrts_pkg::cnt_t  idx_reg, idx_next;
    rrts_pkg::slot_t pick_reg, pick_next;   // thread chosen by yield

    // result word
    logic            done_reg, done_next;
    logic            sw_reg, sw_next;
    rrts_pkg::cnt_t  woken_reg, woken_next;

    // configuration
    logic [rrts_pkg::SLICE_W-1:0] tsl_reg;
    rrts_pkg::slot_t idle_reg;
    rrts_pkg::slot_t boot_reg;

    // ---------------- memories ----------------
    // link RAM: lower half ready_link, upper half sleep_link
    logic                          link_we;
    logic [rrts_pkg::LINK_AW-1:0]  link_waddr, link_raddr;
    rrts_pkg::slot_t               link_wdata, link_rdata;
    logic                          due_we;
    rrts_pkg::slot_t               due_waddr, due_raddr;
    rrts_pkg::tick_t               due_rdata;

    rrts_ram #(.WIDTH(rrts_pkg::SLOT_W), .DEPTH(2 * rrts_pkg::MAX_THREADS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    rrts_ram #(.WIDTH(rrts_pkg::TICK_BITS), .DEPTH(rrts_pkg::MAX_THREADS)) u_due_ram (
        .clk   (clk),
        .we    (due_we),
        .waddr (due_waddr),
        .wdata (wake_reg),
        .raddr (due_raddr),
        .rdata (due_rdata)
    );

    // ---------------- slot table ----------------
    rrts_pkg::slot_wr_t slot_wr;
    rrts_pkg::slot_t    slot_rd_addr;
    rrts_pkg::stat_t    slot_stat;
    logic               slot_mark;

    rrts_slot_table u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (slot_wr),
        .rd_addr (slot_rd_addr),
        .rd_stat (slot_stat),
        .rd_mark (slot_mark)
    );

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsl_reg  <= rrts_pkg::SLICE_RESET;
            idle_reg <= rrts_pkg::IDLE_RESET;
            boot_reg <= rrts_pkg::BOOTSTRAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rrts_pkg::CFG_SLICE:
                begin
                    tsl_reg <= (cfg_data == '0) ? rrts_pkg::SLICE_W'(1) : cfg_data;
                end
                rrts_pkg::CFG_IDLE:      idle_reg <= cfg_data[rrts_pkg::SLOT_W-1:0];
                rrts_pkg::CFG_BOOTSTRAP: boot_reg <= cfg_data[rrts_pkg::SLOT_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rrts_pkg::S_IDLE;
            r_head_reg  <= '0;
            r_tail_reg  <= '0;
            r_total_reg <= '0;
            s_head_reg  <= '0;
            s_total_reg <= '0;
            running_reg <= rrts_pkg::BOOTSTRAP_RESET;
            slice_reg   <= '0;
            resched_reg <= 1'b0;
            done_reg    <= 1'b0;
            sw_reg      <= 1'b0;
            woken_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            r_head_reg  <= r_head_next;
            r_tail_reg  <= r_tail_next;
            r_total_reg <= r_total_next;
            s_head_reg  <= s_head_next;
            s_total_reg <= s_total_next;
            running_reg <= running_next;
            slice_reg   <= slice_next;
            resched_reg <= resched_next;
            done_reg    <= done_next;
            sw_reg      <= sw_next;
            woken_reg   <= woken_next;
        end
    end

    // command payload and walk pointers: no reset needed
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tid_reg  <= tid_next;
        wake_reg <= wake_next;
        now_reg  <= now_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        idx_reg  <= idx_next;
        pick_reg <= pick_next;
    end

    // ---------------- sequencer ----------------
    logic            enq_go;
    rrts_pkg::slot_t enq_slot;
    logic            finish;
    logic [rrts_pkg::SLICE_W-1:0] slice_inc;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        tid_next     = tid_reg;
        wake_next    = wake_reg;
        now_next     = now_reg;
        r_head_next  = r_head_reg;
        r_tail_next  = r_tail_reg;
        r_total_next = r_total_reg;
        s_head_next  = s_head_reg;
        s_total_next = s_total_reg;
        running_next = running_reg;
        slice_next   = slice_reg;
        resched_next = resched_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        idx_next     = idx_reg;
        pick_next    = pick_reg;
        sw_next      = sw_reg;
        woken_next   = woken_reg;
        finish       = 1'b0;
        enq_go       = 1'b0;
        enq_slot     = tid_reg;
        slice_inc    = (slice_reg == '1) ? slice_reg : slice_reg + 1'b1;

        link_we    = 1'b0;
        link_waddr = {rrts_pkg::LIST_READY, r_tail_reg};
        link_wdata = tid_reg;
        link_raddr = {rrts_pkg::LIST_SLEEP, cur_reg};
        due_we     = 1'b0;
        due_waddr  = tid_reg;
        due_raddr  = cur_reg;

        slot_wr = '{stat_we: 1'b0, stat_addr: tid_reg, stat_val: rrts_pkg::ST_READY,
                    mark_we: 1'b0, mark_addr: tid_reg, mark_val: 1'b0};

        unique case (state_reg)
            rrts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    tid_next   = thread_id;
                    wake_next  = wake_tick;
                    now_next   = now_tick;
                    sw_next    = 1'b0;
                    woken_next = '0;
                    state_next = rrts_pkg::S_EXEC;
                end
            end

            // every 5-bit slot number is in range, so no range guard
            rrts_pkg::S_EXEC:
            begin
                priority case (op_reg)
                    rrts_pkg::OP_ENQUEUE:
                    begin
                        enq_go = 1'b1;
                        finish = 1'b1;
                    end
                    rrts_pkg::OP_SLEEP:
                    begin
                        cur_next   = s_head_reg;
                        prev_next  = '0;
                        idx_next   = '0;
                        state_next = rrts_pkg::S_UNL;
                    end
                    rrts_pkg::OP_TICK:
                    begin
                        state_next = rrts_pkg::S_TK;
                    end
                    rrts_pkg::OP_YIELD:
                    begin
                        slice_next   = '0;
                        resched_next = 1'b0;
                        state_next   = rrts_pkg::S_Y_ENQ;
                    end
                    rrts_pkg::OP_BLOCK:
                    begin
                        slot_wr.stat_we  = 1'b1;
                        slot_wr.stat_val = rrts_pkg::ST_BLOCKED;
                        finish           = 1'b1;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            // unlink a thread already sleeping
            rrts_pkg::S_UNL:
            begin
                link_raddr = {rrts_pkg::LIST_SLEEP, cur_reg};
                state_next = (idx_reg == s_total_reg) ? rrts_pkg::S_INS_START
                                                      : rrts_pkg::S_UNL_W;
            end

            rrts_pkg::S_UNL_W:
            begin
                if (cur_reg == tid_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        s_head_next = link_rdata;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = {rrts_pkg::LIST_SLEEP, prev_reg};
                        link_wdata = link_rdata;
                    end
                    s_total_next = s_total_reg - 1'b1;
                    state_next   = rrts_pkg::S_INS_START;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = rrts_pkg::S_UNL;
                end
            end

            rrts_pkg::S_INS_START:
            begin
                due_we     = 1'b1;
                cur_next   = s_head_reg;
                prev_next  = '0;
                idx_next   = '0;
                state_next = rrts_pkg::S_INS;
            end

            rrts_pkg::S_INS:
            begin
                link_raddr = {rrts_pkg::LIST_SLEEP, cur_reg};
                due_raddr  = cur_reg;
                state_next = (idx_reg == s_total_reg) ? rrts_pkg::S_INS_END
                                                      : rrts_pkg::S_INS_W;
            end

            // equal wake ticks keep walking, so the new one goes after them
            rrts_pkg::S_INS_W:
            begin
                if (due_rdata > wake_reg)
                begin
                    state_next = rrts_pkg::S_INS_END;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = rrts_pkg::S_INS;
                end
            end

            rrts_pkg::S_INS_END:
            begin
                if (idx_reg != s_total_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = {rrts_pkg::LIST_SLEEP, tid_reg};
                    link_wdata = cur_reg;
                end
                if (idx_reg == '0)
                begin
                    s_head_next = tid_reg;
                end
                state_next = rrts_pkg::S_INS_LINK;
            end

            rrts_pkg::S_INS_LINK:
            begin
                if (idx_reg != '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = {rrts_pkg::LIST_SLEEP, prev_reg};
                    link_wdata = tid_reg;
                end
                s_total_next = s_total_reg + 1'b1;
                finish       = 1'b1;
            end

            // timer tick: pop due sleepers one by one
            rrts_pkg::S_TK:
            begin
                link_raddr = {rrts_pkg::LIST_SLEEP, s_head_reg};
                due_raddr  = s_head_reg;
                if (s_total_reg == '0)
                begin
                    slice_next = slice_inc;
                    if (slice_inc >= tsl_reg)
                    begin
                        resched_next = 1'b1;
                    end
                    finish = 1'b1;
                end
                else
                begin
                    state_next = rrts_pkg::S_TK_W;
                end
            end

            rrts_pkg::S_TK_W:
            begin
                if (due_rdata > now_reg)
                begin
                    slice_next = slice_inc;
                    if (slice_inc >= tsl_reg)
                    begin
                        resched_next = 1'b1;
                    end
                    finish = 1'b1;
                end
                else
                begin
                    enq_go       = 1'b1;
                    enq_slot     = s_head_reg;
                    if (s_total_reg > rrts_pkg::CNT_W'(1))
                    begin
                        s_head_next = link_rdata;
                    end
                    s_total_next = s_total_reg - 1'b1;
                    woken_next   = woken_reg + 1'b1;
                    state_next   = rrts_pkg::S_TK;
                end
            end

            // yield: requeue the current thread if running and neither idle nor bootstrap slot
            rrts_pkg::S_Y_ENQ:
            begin
                enq_slot = running_reg;
                if (slot_stat == rrts_pkg::ST_RUNNING && running_reg != idle_reg &&
                    running_reg != boot_reg)
                begin
                    enq_go = 1'b1;
                end
                state_next = rrts_pkg::S_Y_DEQ;
            end

            rrts_pkg::S_Y_DEQ:
            begin
                link_raddr = {rrts_pkg::LIST_READY, r_head_reg};
                if (r_total_reg == '0)
                begin
                    pick_next  = idle_reg;
                    state_next = rrts_pkg::S_Y_FIN;
                end
                else
                begin
                    state_next = rrts_pkg::S_Y_DEQ_W;
                end
            end

            rrts_pkg::S_Y_DEQ_W:
            begin
                pick_next = r_head_reg;
                if (r_total_reg > rrts_pkg::CNT_W'(1))
                begin
                    r_head_next = link_rdata;
                end
                r_total_next      = r_total_reg - 1'b1;
                slot_wr.mark_we   = 1'b1;
                slot_wr.mark_addr = r_head_reg;
                slot_wr.mark_val  = 1'b0;
                state_next        = rrts_pkg::S_Y_FIN;
            end

            rrts_pkg::S_Y_FIN:
            begin
                slot_wr.stat_we   = 1'b1;
                slot_wr.stat_addr = pick_reg;
                slot_wr.stat_val  = rrts_pkg::ST_RUNNING;
                if (pick_reg != running_reg)
                begin
                    running_next = pick_reg;
                    sw_next      = 1'b1;
                end
                finish = 1'b1;
            end

            default:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
        endcase

        // shared ready-queue append
        if (enq_go)
        begin
            slot_wr.stat_we   = 1'b1;
            slot_wr.stat_addr = enq_slot;
            slot_wr.stat_val  = rrts_pkg::ST_READY;
            if (!slot_mark)
            begin
                if (r_total_reg == '0)
                begin
                    r_head_next = enq_slot;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = {rrts_pkg::LIST_READY, r_tail_reg};
                    link_wdata = enq_slot;
                end
                r_tail_next       = enq_slot;
                r_total_next      = r_total_reg + 1'b1;
                slot_wr.mark_we   = 1'b1;
                slot_wr.mark_addr = enq_slot;
                slot_wr.mark_val  = 1'b1;
            end
        end

        if (finish)
        begin
            state_next = rrts_pkg::S_IDLE;
        end
        done_next = finish;
    end

    assign slot_rd_addr = enq_slot;

    // ---------------- outputs ----------------
    assign busy            = (state_reg != rrts_pkg::S_IDLE);
    assign done            = done_reg;
    assign current_thread  = running_reg;
    assign switched        = sw_reg;
    assign need_reschedule = resched_reg;
    assign woken_count     = woken_reg;
    assign ready_count     = r_total_reg;

endmodule

`default_nettype wire

[verif/tb_round_robin_thread_scheduler_top.sv]
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler_top: regression bench for the thread scheduler
// Drives enqueue, sleep, tick, yield, block and unknown commands with random
// gaps. A scoreboard class keeps its own copy of the scheduler state, predicts
// each result word and checks every done word against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_round_robin_thread_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrts_pkg::*;

    // Scheduler shadow: predicts result words and holds them until done.
    class sched_scoreboard;
        logic [31:0] slice_len;
        slot_t       idle_slot;
        slot_t       boot_slot;
        stat_t       status [MAX_THREADS];
        bit          queued [MAX_THREADS];
        slot_t       rlink  [MAX_THREADS];
        slot_t       rhead, rtail;
        int          rtotal;
        slot_t       slink  [MAX_THREADS];
        tick_t       sdue   [MAX_THREADS];
        slot_t       shead;
        int          stotal;
        slot_t       running;
        logic [31:0] slice_cnt;
        bit          resched;
        // pending words: {current, switched, resched, woken, ready}
        logic [18:0] pending [$];
        int          errors;
        int          checked;
        int          switches;
        int          wakeups;

        function new();
            slice_len = SLICE_RESET;
            idle_slot = IDLE_RESET;
            boot_slot = BOOTSTRAP_RESET;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                status[i] = ST_BLOCKED;
                queued[i] = 0;
            end
            rhead = 0; rtail = 0; rtotal = 0;
            shead = 0; stotal = 0;
            running = boot_slot;
            status[running] = ST_RUNNING;
            slice_cnt = 0;
            resched = 0;
            errors = 0; checked = 0; switches = 0; wakeups = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_SLICE:     slice_len = (val == 0) ? 32'd1 : val;
                CFG_IDLE:      idle_slot = val[SLOT_W-1:0];
                CFG_BOOTSTRAP: boot_slot = val[SLOT_W-1:0];
                default: ;
            endcase
        endfunction

        function void make_ready(slot_t t);
            status[t] = ST_READY;
            if (queued[t]) return;
            if (rtotal == 0) rhead = t;
            else rlink[rtail] = t;
            rtail = t;
            rtotal++;
            queued[t] = 1;
        endfunction

        function slot_t pop_ready();
            slot_t t;
            if (rtotal == 0) return idle_slot;
            t = rhead;
            if (rtotal > 1) rhead = rlink[t];
            rtotal--;
            queued[t] = 0;
            return t;
        endfunction

        function void unlink_sleeper(slot_t t);
            slot_t cur, prev;
            cur = shead;
            prev = 0;
            for (int i = 0; i < stotal; i++)
            begin
                if (cur == t)
                begin
                    if (i == 0) shead = slink[cur];
                    else slink[prev] = slink[cur];
                    stotal--;
                    return;
                end
                prev = cur;
                cur = slink[cur];
            end
        endfunction

        function void add_sleeper(slot_t t, tick_t due);
            slot_t cur, prev;
            int    i;
            unlink_sleeper(t);
            sdue[t] = due;
            cur = shead;
            prev = 0;
            for (i = 0; i < stotal; i++)
            begin
                if (sdue[cur] > due) break;
                prev = cur;
                cur = slink[cur];
            end
            if (i < stotal) slink[t] = cur;
            if (i == 0) shead = t;
            else slink[prev] = t;
            stotal++;
        endfunction

        // accepted command word: advance the shadow, queue the expected word
        function void note_command(logic [2:0] op, slot_t tid, tick_t wake, tick_t now);
            int    woken;
            bit    sw;
            slot_t curr, nxt;
            woken = 0;
            sw = 0;
            case (op)
                OP_ENQUEUE: make_ready(tid);
                OP_SLEEP:   add_sleeper(tid, wake);
                OP_TICK:
                begin
                    while (stotal > 0 && sdue[shead] <= now)
                    begin
                        curr = shead;
                        if (stotal > 1) shead = slink[curr];
                        stotal--;
                        make_ready(curr);
                        woken++;
                    end
                    if (slice_cnt != 32'hFFFF_FFFF) slice_cnt++;
                    if (slice_cnt >= slice_len) resched = 1;
                end
                OP_YIELD:
                begin
                    curr = running;
                    slice_cnt = 0;
                    resched = 0;
                    if (status[curr] == ST_RUNNING && curr != idle_slot && curr != boot_slot)
                        make_ready(curr);
                    nxt = pop_ready();
                    status[nxt] = ST_RUNNING;
                    if (nxt != curr)
                    begin
                        running = nxt;
                        sw = 1;
                    end
                end
                OP_BLOCK:   status[tid] = ST_BLOCKED;
                default: ;
            endcase
            switches += sw;
            wakeups += woken;
            pending.push_back({running, sw, resched, woken[5:0], rtotal[5:0]});
        endfunction

        function void check_word(slot_t cur, logic sw, logic rs, cnt_t wk, cnt_t rc);
            logic [18:0] exp_word;
            checked++;
            if (pending.size() == 0)
            begin
                $error("done word with nothing expected");
                errors++;
                return;
            end
            exp_word = pending.pop_front();
            if (cur !== exp_word[18:14])
            begin
                $error("current_thread exp %0d got %0d", exp_word[18:14], cur);
                errors++;
            end
            if (sw !== exp_word[13])
            begin
                $error("switched exp %0d got %0d", exp_word[13], sw);
                errors++;
            end
            if (rs !== exp_word[12])
            begin
                $error("need_reschedule exp %0d got %0d", exp_word[12], rs);
                errors++;
            end
            if (wk !== exp_word[11:6])
            begin
                $error("woken_count exp %0d got %0d", exp_word[11:6], wk);
                errors++;
            end
            if (rc !== exp_word[5:0])
            begin
                $error("ready_count exp %0d got %0d", exp_word[5:0], rc);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  operation;
    slot_t       thread_id;
    tick_t       wake_tick;
    tick_t       now_tick;
    logic        done;
    slot_t       current_thread;
    logic        switched;
    logic        need_reschedule;
    cnt_t        woken_count;
    cnt_t        ready_count;
    logic        cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sched_scoreboard sb;
    tick_t           tick_now;   // running tick value for well-formed traffic
    int              sent;

    round_robin_thread_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .operation(operation), .thread_id(thread_id),
        .wake_tick(wake_tick), .now_tick(now_tick),
        .done(done), .current_thread(current_thread), .switched(switched),
        .need_reschedule(need_reschedule), .woken_count(woken_count),
        .ready_count(ready_count),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: every done word is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(current_thread, switched, need_reschedule, woken_count, ready_count);
    end

    // Hard stop: far above the slowest legal run of about 850 command words.
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One command word: random gap, then hold start until it is taken.
    // With no gap start stays high straight into the next word.
    task automatic send_word(logic [2:0] op, slot_t tid, tick_t wake, tick_t now);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no idling
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        thread_id <= tid;
        wake_tick <= wake;
        now_tick  <= now;
        @(posedge clk);
        while (busy) @(posedge clk);
        // word taken at this edge
        sb.note_command(op, tid, wake, now);
        sent++;
    endtask

    // Hold off until the block has answered everything, plus tail slack.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic mostly built from legal slots and near-future wake ticks;
    // some words are raw noise across every field bit.
    task automatic random_phase(int count);
        int    pick;
        logic [2:0] op;
        slot_t tid;
        tick_t wake;
        tick_t now;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            tid  = $urandom_range(0, 31);
            wake = tick_now + $urandom_range(0, 12);
            now  = tick_now;
            if (pick < 25)      op = OP_ENQUEUE;
            else if (pick < 45) op = OP_SLEEP;
            else if (pick < 68)
            begin
                op = OP_TICK;
                tick_now = tick_now + $urandom_range(0, 3);
                now = tick_now;
            end
            else if (pick < 85) op = OP_YIELD;
            else if (pick < 92) op = OP_BLOCK;
            else
            begin
                op   = $urandom_range(0, 7);
                wake = $urandom;
                now  = $urandom;
            end
            send_word(op, tid, wake, now);
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = '0;
        thread_id = '0;
        wake_tick = '0;
        now_tick  = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tick_now  = 32'd100;
        sent      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation, unknown codes, field extremes, re-sleep,
        // double enqueue, blocked thread at yield, equal wake ticks.
        send_word(OP_YIELD,   0, 0, 0);                   // empty queue -> idle
        send_word(OP_ENQUEUE, 5, 0, 0);
        send_word(OP_ENQUEUE, 5, 0, 0);                   // not queued twice
        send_word(OP_ENQUEUE, 31, 0, 0);
        send_word(OP_YIELD,   0, 0, 0);
        send_word(OP_BLOCK,   5, 0, 0);                   // current goes blocked
        send_word(OP_YIELD,   0, 0, 0);                   // not requeued
        send_word(OP_SLEEP,   7, 32'd50, 0);
        send_word(OP_SLEEP,   8, 32'd50, 0);              // equal tick goes after
        send_word(OP_SLEEP,   9, 32'hFFFF_FFFF, 0);
        send_word(OP_SLEEP,   7, 32'd60, 0);              // re-sleep
        send_word(OP_SLEEP,   10, 32'd0, 0);
        send_word(OP_TICK,    0, 0, 32'd0);
        send_word(OP_TICK,    0, 0, 32'd60);
        send_word(OP_TICK,    0, 0, 32'hFFFF_FFFF);
        send_word(3'd5,       3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(3'd6,       0, 0, 0);
        send_word(3'd7,       31, 0, 0);
        send_word(OP_YIELD,   0, 0, 0);
        send_word(OP_TICK,    0, 0, 32'd0);
        send_word(OP_TICK,    0, 0, 32'd0);
        drain();

        // Settings sweep, extremes included. Config only with nothing in flight.
        write_cfg(CFG_SLICE, 32'd0);                      // stores one
        write_cfg(CFG_IDLE, 32'd31);
        write_cfg(CFG_BOOTSTRAP, 32'd0);
        random_phase(200);
        drain();                                          // sender waits all out
        write_cfg(CFG_SLICE, 32'hFFFF_FFFF);
        write_cfg(CFG_IDLE, 32'd3);
        write_cfg(CFG_BOOTSTRAP, 32'd31);
        random_phase(200);
        drain();
        write_cfg(CFG_SLICE, 32'd3);
        write_cfg(CFG_IDLE, 32'd0);
        write_cfg(CFG_BOOTSTRAP, 32'd1);
        random_phase(220);
        drain();
        write_cfg(CFG_SLICE, $urandom_range(1, 10));
        write_cfg(CFG_IDLE, $urandom_range(0, 31));
        write_cfg(CFG_BOOTSTRAP, $urandom_range(0, 31));
        random_phase(210);
        drain();

        $display("covered %0d command words, %0d results checked", sent, sb.checked);
        $display("thread switches %0d, sleepers woken %0d", sb.switches, sb.wakeups);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
